// ===== rtl/ple_pkg.sv =====
// ple_pkg: sizes, command and status codes, and shared types for the
// positional list engine. No dependencies.
package ple_pkg;

	localparam int CAPACITY   = 32;
	localparam int DATA_WIDTH = 32;

	localparam int OP_W  = 3;
	localparam int POS_W = 6;
	localparam int VAL_W = 32;
	localparam int ST_W  = 3;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
	localparam logic [OP_W-1:0] OP_GET    = 3'd2;
	localparam logic [OP_W-1:0] OP_LOCATE = 3'd3;
	localparam logic [OP_W-1:0] OP_LENGTH = 3'd4;

	localparam logic [ST_W-1:0] ST_OK     = 3'd0;
	localparam logic [ST_W-1:0] ST_BADPOS = 3'd1;
	localparam logic [ST_W-1:0] ST_UNDER  = 3'd2;
	localparam logic [ST_W-1:0] ST_FULL   = 3'd3;
	localparam logic [ST_W-1:0] ST_MISS   = 3'd4;

	typedef logic [DATA_WIDTH-1:0] word_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	// broadcast to every cell
	typedef struct packed {
		logic  take;
		logic  ins;
		logic  del;
		idx_t  p;
		cnt_t  count;
		word_t val;
	} cell_cmd_t;

	// per-item control carried from the cell row to the output stage
	typedef struct packed {
		logic             rd_en;
		logic             loc;
		logic [ST_W-1:0]  status;
		logic [POS_W-1:0] len;
	} item_ctl_t;

	function automatic logic [VAL_W-1:0] widen(input word_t w);
		logic signed [DATA_WIDTH-1:0] s;
		s = signed'(w);
		return VAL_W'(s);
	endfunction

endpackage

// ===== rtl/ple_cell.sv =====
// ple_cell: one list entry. Shifts with its neighbors on insert and delete,
// and registers its match and read contribution for the item. Uses ple_pkg.
module ple_cell (
	input  logic               clk,
	input  ple_pkg::idx_t      idx,
	input  ple_pkg::cell_cmd_t cmd,
	input  ple_pkg::word_t     left_data,
	input  ple_pkg::word_t     right_data,
	output ple_pkg::word_t     data,
	output logic               match_s1,
	output ple_pkg::word_t     word_s1
);
	import ple_pkg::*;

	word_t data_q;
	logic  hit;
	logic  live;

	assign data = data_q;
	assign hit  = (idx == cmd.p);
	assign live = (CNT_W'(idx) < cmd.count);

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (idx > cmd.p) begin
				data_q <= left_data;
			end else if (hit) begin
				data_q <= cmd.val;
			end
		end else if (cmd.del) begin
			if (idx >= cmd.p) begin
				data_q <= right_data;
			end
		end
		if (cmd.take) begin
			match_s1 <= live && (data_q == cmd.val);
			word_s1  <= hit ? data_q : '0;
		end
	end

endmodule

// ===== rtl/ple_collect.sv =====
// ple_collect: output stage. Priority-encodes the cell match flags, merges
// the cell read words and holds the result item. Uses ple_pkg.
module ple_collect (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          valid_s1,
	input  ple_pkg::item_ctl_t                            ctl_s1,
	input  logic [ple_pkg::CAPACITY-1:0]                  match,
	input  logic [ple_pkg::CAPACITY-1:0][ple_pkg::DATA_WIDTH-1:0] words,
	output logic                                          ready_s1,
	output logic                                          out_valid,
	input  logic                                          out_ready,
	output logic signed [ple_pkg::VAL_W-1:0]              read_value,
	output logic [ple_pkg::POS_W-1:0]                     found_position,
	output logic [ple_pkg::POS_W-1:0]                     list_length,
	output logic [ple_pkg::ST_W-1:0]                      status
);
	import ple_pkg::*;

	logic                out_valid_q;
	logic [VAL_W-1:0]    rd_q;
	logic [POS_W-1:0]    found_q;
	logic [POS_W-1:0]    len_q;
	logic [ST_W-1:0]     st_q;
	word_t               merged;
	logic [POS_W-1:0]    first;
	logic                any;

	always_comb begin
		merged = '0;
		first  = '0;
		any    = 1'b0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			merged = merged | words[i];
			if (match[i]) begin
				first = POS_W'(i + 1);
				any   = 1'b1;
			end
		end
	end

	assign ready_s1 = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1) begin
			out_valid_q <= ready_s1 ? 1'b1 : out_valid_q;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s1) begin
			rd_q    <= ctl_s1.rd_en ? widen(merged) : '0;
			found_q <= (ctl_s1.loc && any) ? first : '0;
			len_q   <= ctl_s1.len;
			if (ctl_s1.loc) begin
				st_q <= any ? ST_OK : ST_MISS;
			end else begin
				st_q <= ctl_s1.status;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign read_value     = signed'(rd_q);
	assign found_position = found_q;
	assign list_length    = len_q;
	assign status         = st_q;

endmodule

// ===== rtl/positional_list_engine_unit.sv =====
// positional_list_engine_unit: top level. Decodes commands, keeps the entry
// count, and drives the row of ple_cell entries and ple_collect. Uses ple_pkg.
//
// Keeps an ordered list of up to 32 signed words in a row of cells, one
// entry per cell. Every cell shifts, loads or holds in the same cycle, so
// an insert or delete at any position finishes in the cycle the item is
// accepted, and the next item can be accepted in the following cycle: one
// item per cycle sustained while the output is not stalled. The result is
// registered first by the cell row, as its match and read flags, then by
// the output stage, which priority-encodes and merges them. The output
// register lets a new item in while a finished result waits to be taken.
module positional_list_engine_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [ple_pkg::OP_W-1:0]          operation,
	input  logic [ple_pkg::POS_W-1:0]         position,
	input  logic signed [ple_pkg::VAL_W-1:0]  value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [ple_pkg::VAL_W-1:0]  read_value,
	output logic [ple_pkg::POS_W-1:0]         found_position,
	output logic [ple_pkg::POS_W-1:0]         list_length,
	output logic [ple_pkg::ST_W-1:0]          status
);
	import ple_pkg::*;

	cnt_t                                   count_q;
	cnt_t                                   count_nx;
	logic                                   valid_s1;
	item_ctl_t                              ctl_s1;
	item_ctl_t                              ctl_nx;
	logic                                   ready_s1;
	logic                                   accept;
	cell_cmd_t                              cmd;
	logic [CMP_W-1:0]                       pos_w;
	logic [CMP_W-1:0]                       pos_eff;
	logic [CMP_W-1:0]                       cnt_w;
	logic                                   ins_ok;
	logic                                   del_ok;
	logic                                   get_ok;
	logic [CAPACITY-1:0][DATA_WIDTH-1:0]    data;
	logic [CAPACITY-1:0][DATA_WIDTH-1:0]    words;
	logic [CAPACITY-1:0]                    match;

	assign in_ready = !valid_s1 || ready_s1;
	assign accept   = in_valid && in_ready;

	assign pos_w   = CMP_W'(position);
	assign pos_eff = (position == '0) ? CMP_W'(1) : pos_w;
	assign cnt_w   = CMP_W'(count_q);

	always_comb begin
		ins_ok   = 1'b0;
		del_ok   = 1'b0;
		get_ok   = 1'b0;
		count_nx = count_q;
		ctl_nx   = '0;
		cmd.p    = idx_t'(pos_w - CMP_W'(1));
		case (operation)
			OP_INSERT: begin
				cmd.p = idx_t'(pos_eff - CMP_W'(1));
				if (cnt_w == CMP_W'(CAPACITY)) begin
					ctl_nx.status = ST_FULL;
				end else if (pos_eff > cnt_w + CMP_W'(1)) begin
					ctl_nx.status = ST_BADPOS;
				end else begin
					ins_ok   = 1'b1;
					count_nx = count_q + cnt_t'(1);
				end
			end
			OP_DELETE: begin
				if (count_q == '0) begin
					ctl_nx.status = ST_UNDER;
				end else if (position == '0 || pos_w > cnt_w) begin
					ctl_nx.status = ST_BADPOS;
				end else begin
					del_ok   = 1'b1;
					count_nx = count_q - cnt_t'(1);
				end
			end
			OP_GET: begin
				if (position == '0 || pos_w > cnt_w) begin
					ctl_nx.status = ST_BADPOS;
				end else begin
					get_ok = 1'b1;
				end
			end
			OP_LOCATE: begin
				ctl_nx.loc = 1'b1;
			end
			default: begin
			end
		endcase
		ctl_nx.rd_en = del_ok || get_ok;
		ctl_nx.len   = POS_W'(count_nx);
		cmd.take     = accept;
		cmd.ins      = accept && ins_ok;
		cmd.del      = accept && del_ok;
		cmd.count    = count_q;
		cmd.val      = DATA_WIDTH'(value);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				count_q  <= count_nx;
				valid_s1 <= 1'b1;
			end else if (ready_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl_nx;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		word_t left_in;
		word_t right_in;
		if (i == 0) begin : g_first
			assign left_in = cmd.val;
		end else begin : g_mid_l
			assign left_in = data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_in = data[i];
		end else begin : g_mid_r
			assign right_in = data[i+1];
		end
		ple_cell u_cell (
			.clk        (clk),
			.idx        (idx_t'(i)),
			.cmd        (cmd),
			.left_data  (left_in),
			.right_data (right_in),
			.data       (data[i]),
			.match_s1   (match[i]),
			.word_s1    (words[i])
		);
	end

	ple_collect u_collect (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_s1       (valid_s1),
		.ctl_s1         (ctl_s1),
		.match          (match),
		.words          (words),
		.ready_s1       (ready_s1),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.read_value     (read_value),
		.found_position (found_position),
		.list_length    (list_length),
		.status         (status)
	);

endmodule

// ===== rtl/ple_checker.sv =====
// ple_checker: port-level checks on the positional list engine results,
// bound to positional_list_engine_unit. Uses ple_pkg.
module ple_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [ple_pkg::VAL_W-1:0]  read_value,
	input logic [ple_pkg::POS_W-1:0]         found_position,
	input logic [ple_pkg::POS_W-1:0]         list_length,
	input logic [ple_pkg::ST_W-1:0]          status
);
	import ple_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_value)
		&& $stable(found_position) && $stable(list_length) && $stable(status))
		else $error("result item changed while stalled");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(list_length) <= 32'(CAPACITY))
		else $error("list length above capacity");

	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_MISS |-> found_position == '0)
		else $error("not found with nonzero position");

	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found_position != '0 |-> status == ST_OK
		&& found_position <= list_length)
		else $error("found position inconsistent");

	a_under: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_UNDER |-> list_length == '0 && read_value == '0)
		else $error("underflow on nonempty list");

endmodule

bind positional_list_engine_unit ple_checker u_ple_checker (.*);

// ===== test/tb_positional_list_engine_unit.sv =====
// Self-checking testbench for positional_list_engine_unit: a clocked driver and
// monitor around a list predictor, with random bursts, stalls and long hold-offs.
// Depends on ple_pkg and the positional_list_engine_unit RTL.
module tb_positional_list_engine_unit;
	import ple_pkg::*;

	localparam int CLK_HALF    = 10;
	localparam int RESET_CYCLES = 11;
	localparam int TARGET_ITEMS = 1350;
	localparam int IDLE_LIMIT   = 2000;
	localparam int HOLD_CYCLES  = 160;
	localparam int DRAIN_CYCLES = 8;

	localparam logic [OP_W-1:0] OP_SPARE = OP_LENGTH + 3'd1;

	typedef struct packed {
		logic [OP_W-1:0]         op;
		logic [POS_W-1:0]        pos;
		logic signed [VAL_W-1:0] val;
	} list_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0]         op;
		logic [POS_W-1:0]        pos;
		logic signed [VAL_W-1:0] read_value;
		logic [POS_W-1:0]        found_position;
		logic [POS_W-1:0]        list_length;
		logic [ST_W-1:0]         status;
	} list_outcome_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [OP_W-1:0]         operation = '0;
	logic [POS_W-1:0]        position = '0;
	logic signed [VAL_W-1:0] value = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [VAL_W-1:0] read_value;
	logic [POS_W-1:0]        found_position;
	logic [POS_W-1:0]        list_length;
	logic [ST_W-1:0]         status;

	list_cmd_t     command_backlog[$];
	list_outcome_t awaited_outcomes[$];
	logic signed [VAL_W-1:0] inserted_pool[$];

	word_t list_store [CAPACITY];
	int    stored_count;
	int    planned_len;
	int    planned_items;
	int    mismatches;
	int    results_taken;
	int    idle_cycles;
	int    burst_left;
	int    gap_left;
	int    hold_left;
	int    next_holdoff;
	int    stall_mode;
	int    mode_left;

	positional_list_engine_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.position      (position),
		.value         (value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.read_value    (read_value),
		.found_position(found_position),
		.list_length   (list_length),
		.status        (status)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	function automatic list_outcome_t apply_list_command(input logic [OP_W-1:0] op,
			input logic [POS_W-1:0] pos, input logic signed [VAL_W-1:0] val);
		list_outcome_t res;
		logic signed [DATA_WIDTH-1:0] w;
		logic signed [DATA_WIDTH-1:0] held;
		int p;
		w = val;
		p = pos;
		res.op = op;
		res.pos = pos;
		res.read_value = '0;
		res.found_position = '0;
		res.status = ST_OK;
		case (op)
		OP_INSERT: begin
			if (p == 0)
				p = 1;
			if (stored_count >= CAPACITY)
				res.status = ST_FULL;
			else if (p > stored_count + 1)
				res.status = ST_BADPOS;
			else begin
				for (int k = stored_count; k >= p; k--)
					list_store[k] = list_store[k-1];
				list_store[p-1] = w;
				stored_count++;
			end
		end
		OP_DELETE: begin
			if (stored_count == 0)
				res.status = ST_UNDER;
			else if (p == 0 || p > stored_count)
				res.status = ST_BADPOS;
			else begin
				held = list_store[p-1];
				res.read_value = held;
				for (int k = p; k < stored_count; k++)
					list_store[k-1] = list_store[k];
				stored_count--;
			end
		end
		OP_GET: begin
			if (p == 0 || p > stored_count)
				res.status = ST_BADPOS;
			else begin
				held = list_store[p-1];
				res.read_value = held;
			end
		end
		OP_LOCATE: begin
			res.status = ST_MISS;
			for (int k = 0; k < stored_count; k++) begin
				if (list_store[k] == w) begin
					res.found_position = POS_W'(k + 1);
					res.status = ST_OK;
					break;
				end
			end
		end
		default: ;
		endcase
		res.list_length = POS_W'(stored_count);
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// queues one item and tracks the length it should leave behind
	task automatic plan_command(input logic [OP_W-1:0] op, input int pos,
			input logic signed [VAL_W-1:0] val);
		list_cmd_t c;
		int p;
		c.op = op;
		c.pos = POS_W'(pos);
		c.val = val;
		command_backlog.push_back(c);
		p = (pos == 0) ? 1 : pos;
		if (op == OP_INSERT && planned_len < CAPACITY && p <= planned_len + 1) begin
			planned_len++;
			inserted_pool.push_back(val);
			if (inserted_pool.size() > CAPACITY)
				void'(inserted_pool.pop_front());
		end
		if (op == OP_DELETE && planned_len > 0 && pos >= 1 && pos <= planned_len)
			planned_len--;
		if (op <= OP_LENGTH)
			planned_items++;
	endtask

	function automatic int pick_position(input logic [OP_W-1:0] op);
		int r;
		r = $urandom_range(0, 9);
		if (r < 8) begin
			if (op == OP_INSERT)
				return $urandom_range(0, planned_len + 1);
			return (planned_len == 0) ? 0 : $urandom_range(1, planned_len);
		end
		if (r == 8)
			return $urandom_range(planned_len + 1, (1 << POS_W) - 1);
		return $urandom_range(0, (1 << POS_W) - 1);
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_value(input int pool_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < pool_pct && inserted_pool.size() > 0)
			return inserted_pool[$urandom_range(0, inserted_pool.size() - 1)];
		if (r < pool_pct + 15) begin
			case ($urandom_range(0, 4))
			0: return {1'b0, {(VAL_W-1){1'b1}}};
			1: return {1'b1, {(VAL_W-1){1'b0}}};
			2: return '1;
			default: return $urandom_range(0, 5);
			endcase
		end
		return $urandom;
	endfunction

	// driver: predicts on acceptance, then offers the next item in bursts
	always @(posedge clk or negedge arst_n) begin : drv_proc
		list_cmd_t nxt;
		logic      drive;
		if (!arst_n) begin
			in_valid <= 1'b0;
			operation <= '0;
			position <= '0;
			value <= '0;
			stored_count = 0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready)
				awaited_outcomes.push_back(apply_list_command(operation, position, value));
			if (!in_valid || in_ready) begin
				drive = 1'b0;
				nxt = '0;
				if (gap_left > 0)
					gap_left--;
				else if (command_backlog.size() > 0) begin
					if (burst_left == 0)
						burst_left = $urandom_range(1, 40);
					nxt = command_backlog.pop_front();
					drive = 1'b1;
					burst_left--;
					if (burst_left == 0)
						gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
				end
				in_valid <= drive;
				if (drive) begin
					operation <= nxt.op;
					position <= nxt.pos;
					value <= nxt.val;
				end
			end
		end
	end

	// receiver: stall pattern in modes, plus a long hold-off every few hundred results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left = 0;
			next_holdoff = 300;
			stall_mode = 0;
			mode_left = 0;
		end else begin
			if (hold_left == 0 && results_taken >= next_holdoff) begin
				hold_left = HOLD_CYCLES;
				next_holdoff += 500;
			end
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 100);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 9) >= 3);
				2: out_ready <= (mode_left % 3 != 0);
				default: out_ready <= ($urandom_range(0, 9) >= 7);
				endcase
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : mon_proc
		list_outcome_t want;
		if (!arst_n)
			results_taken <= 0;
		else if (out_valid && out_ready) begin
			results_taken <= results_taken + 1;
			if (awaited_outcomes.size() == 0)
				report_mismatch("result with nothing awaited");
			else begin
				want = awaited_outcomes.pop_front();
				if (read_value !== want.read_value)
					report_mismatch($sformatf("op %0d pos %0d read_value got %0d exp %0d",
						want.op, want.pos, read_value, want.read_value));
				if (found_position !== want.found_position)
					report_mismatch($sformatf("op %0d pos %0d found_position got %0d exp %0d",
						want.op, want.pos, found_position, want.found_position));
				if (list_length !== want.list_length)
					report_mismatch($sformatf("op %0d pos %0d list_length got %0d exp %0d",
						want.op, want.pos, list_length, want.list_length));
				if (status !== want.status)
					report_mismatch($sformatf("op %0d pos %0d status got %0d exp %0d",
						want.op, want.pos, status, want.status));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		int phase;
		int span;
		int r;
		logic [OP_W-1:0] op;
		planned_len = 0;
		planned_items = 0;

		// directed: empty list, zero and out-of-range positions, extremes, first match
		plan_command(OP_LENGTH, 0, 0);
		plan_command(OP_DELETE, 1, 0);
		plan_command(OP_GET, 0, 0);
		plan_command(OP_GET, 1, 0);
		plan_command(OP_LOCATE, 0, 0);
		plan_command(OP_INSERT, 0, {1'b0, {(VAL_W-1){1'b1}}});
		plan_command(OP_INSERT, 2, {1'b1, {(VAL_W-1){1'b0}}});
		plan_command(OP_INSERT, 1, '1);
		plan_command(OP_INSERT, 5, 7);
		plan_command(OP_INSERT, (1 << POS_W) - 1, 7);
		plan_command(OP_INSERT, 4, '1);
		plan_command(OP_GET, 0, 0);
		plan_command(OP_GET, 3, 0);
		plan_command(OP_GET, 5, 0);
		plan_command(OP_LOCATE, 0, {1'b1, {(VAL_W-1){1'b0}}});
		plan_command(OP_LOCATE, 0, '1);
		plan_command(OP_LOCATE, 0, 0);
		plan_command(OP_DELETE, 0, 0);
		plan_command(OP_DELETE, (1 << POS_W) - 1, 0);
		plan_command(OP_DELETE, 2, 0);
		plan_command(OP_LENGTH, (1 << POS_W) - 1, '1);
		for (int k = OP_SPARE; k < (1 << OP_W); k++)
			plan_command(OP_W'(k), $urandom_range(0, (1 << POS_W) - 1), $urandom);

		// random: fill, drain and mixed phases so the list reaches full and empty
		while (planned_items < TARGET_ITEMS) begin
			phase = $urandom_range(0, 2);
			span = $urandom_range(30, 90);
			for (int n = 0; n < span; n++) begin
				r = $urandom_range(0, 99);
				case (phase)
				0: op = (r < 65) ? OP_INSERT : (r < 75) ? OP_GET : (r < 85) ? OP_LOCATE :
					(r < 92) ? OP_DELETE : (r < 97) ? OP_LENGTH : OP_SPARE;
				1: op = (r < 60) ? OP_DELETE : (r < 70) ? OP_INSERT : (r < 80) ? OP_GET :
					(r < 90) ? OP_LOCATE : (r < 97) ? OP_LENGTH : OP_SPARE;
				default: op = (r < 30) ? OP_INSERT : (r < 55) ? OP_DELETE : (r < 70) ? OP_GET :
					(r < 90) ? OP_LOCATE : (r < 97) ? OP_LENGTH : OP_SPARE;
				endcase
				if (op > OP_LENGTH)
					plan_command(OP_W'($urandom_range(OP_SPARE, (1 << OP_W) - 1)),
						$urandom_range(0, (1 << POS_W) - 1), $urandom);
				else if (op == OP_INSERT || op == OP_DELETE || op == OP_GET)
					plan_command(op, pick_position(op),
						pick_value((op == OP_INSERT) ? 15 : 0));
				else
					plan_command(op, $urandom_range(0, (1 << POS_W) - 1),
						pick_value((op == OP_LOCATE) ? 70 : 0));
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		while (command_backlog.size() > 0 || in_valid || awaited_outcomes.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && awaited_outcomes.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
